@@ rtl/core/asu_pkg.sv @@
package asu_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int VAL_W     = 32;

  typedef struct packed {
    logic signed [VAL_W-1:0] sample_value;
    logic                    last_in;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] sorted_value;
    logic                    last_out;
    logic                    overflow;
  } out_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;    // insert the broadcast value in order
    logic shift;  // move every entry one cell toward cell 0
  } cell_ctl_t;

endpackage

@@ rtl/core/asu_cell.sv @@
module asu_cell (
  input  logic                             clk,
  input  logic                             rst_n,
  input  asu_pkg::cell_ctl_t               ctl,
  input  logic signed [asu_pkg::VAL_W-1:0] ins_value,
  input  logic signed [asu_pkg::VAL_W-1:0] prev_value,
  input  logic                             prev_valid,
  input  logic                             prev_gt,
  input  logic signed [asu_pkg::VAL_W-1:0] next_value,
  input  logic                             next_valid,
  output logic signed [asu_pkg::VAL_W-1:0] value,
  output logic                             valid,
  output logic                             gt
);

  logic signed [asu_pkg::VAL_W-1:0] value_r, value_nxt;
  logic                             valid_r, valid_nxt;

  // cell is empty or holds something larger than the new value
  assign gt = !valid_r || (ins_value < value_r);

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.shift) begin
      value_nxt = next_value;
      valid_nxt = next_valid;
    end else if (ctl.ins && gt) begin
      if (prev_gt) begin
        value_nxt = prev_value;
        valid_nxt = prev_valid;
      end else begin
        value_nxt = ins_value;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign value = value_r;
  assign valid = valid_r;

endmodule

@@ rtl/core/array_ascending_sorter_unit.sv @@
// Channel | Ports                          | Transfer when
// --------+--------------------------------+-------------------------------
// input   | start, busy, in_data (in_t)    | rising edge, start & !busy
// result  | out_valid, out_data (out_t)    | rising edge with out_valid high
//
// Values are inserted into a sorted row of DEPTH cells, one per cycle while
// busy is low: each cell compares the new value against its own entry and
// keeps it or takes either the new value or its left neighbor's entry. On a
// last item the row then drains toward cell 0, one result per cycle; busy
// is high during the drain, so no new value is taken until the set has left.
// Results trail the drain by one register.
// Reset (rst_n low, synchronous) empties the row and clears count and flags.
// The receiver cannot stall; results are presented for one cycle only.
module array_ascending_sorter_unit #(
  parameter int DEPTH = asu_pkg::DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  asu_pkg::in_t  in_data,
  output logic          out_valid,
  output asu_pkg::out_t out_data
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);
  localparam logic [CW-1:0] ONE  = CW'(1);

  logic                             accept;
  logic                             room;
  asu_pkg::cell_ctl_t               ctl;

  // count_r: values stored this set; counts down during the drain
  logic [CW-1:0]                    count_r, count_nxt;
  logic                             drain_r, drain_nxt;
  logic                             ovf_r, ovf_nxt;
  logic                             out_valid_r, out_valid_nxt;
  asu_pkg::out_t                    out_data_r, out_data_nxt;

  logic signed [asu_pkg::VAL_W-1:0] cval  [DEPTH];
  logic                             cvld  [DEPTH];
  logic                             cgt   [DEPTH];

  assign accept = start && !drain_r;
  assign room   = (count_r != FULL);
  assign ctl    = '{ins: accept && room, shift: drain_r};

  // --- row of sorting cells ---
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [asu_pkg::VAL_W-1:0] pv, nv;
    logic                             pvl, pgt, nvl;
    if (i == 0) begin : g_first
      assign pv  = '0;
      assign pvl = 1'b0;
      assign pgt = 1'b0;
    end else begin : g_mid
      assign pv  = cval[i-1];
      assign pvl = cvld[i-1];
      assign pgt = cgt[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign nv  = '0;
      assign nvl = 1'b0;
    end else begin : g_inner
      assign nv  = cval[i+1];
      assign nvl = cvld[i+1];
    end
    asu_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .ins_value  (in_data.sample_value),
      .prev_value (pv),
      .prev_valid (pvl),
      .prev_gt    (pgt),
      .next_value (nv),
      .next_valid (nvl),
      .value      (cval[i]),
      .valid      (cvld[i]),
      .gt         (cgt[i])
    );
  end

  // --- sequencing ---
  always_comb begin
    count_nxt     = count_r;
    drain_nxt     = drain_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    if (drain_r) begin
      // cell 0 holds the smallest remaining value
      out_valid_nxt             = 1'b1;
      out_data_nxt.sorted_value = cval[0];
      out_data_nxt.last_out     = (count_r == ONE);
      out_data_nxt.overflow     = ovf_r;
      count_nxt                 = count_r - ONE;
      if (count_r == ONE) begin
        drain_nxt = 1'b0;
        ovf_nxt   = 1'b0;
      end
    end else if (accept) begin
      if (room) begin
        count_nxt = count_r + ONE;
      end else begin
        ovf_nxt = 1'b1;
      end
      if (in_data.last_in) begin
        drain_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (!rst_n) begin
      count_r     <= '0;
      drain_r     <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      drain_r     <= drain_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy      = drain_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // --- checks ---
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL)
    else $error("stored count beyond depth");

  a_drain_emits: assert property (@(posedge clk) disable iff (!rst_n)
    drain_r |=> out_valid_r)
    else $error("drain cycle without result");

  a_last_starts_drain: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.last_in |=> drain_r)
    else $error("last value did not start drain");

  a_final_frees: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.last_out |-> !drain_r && count_r == '0 && !ovf_r)
    else $error("set not cleared after final result");

endmodule
